/* sv/ssq_pkg.sv */
// Package with shared types and codes of the sorted-stack priority queue.
package ssq_pkg;

  // Operation codes carried on the kind input.
  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  // Error codes reported with each result.
  localparam logic [1:0] ERR_OK        = 2'd0;
  localparam logic [1:0] ERR_POP_EMPTY = 2'd1;
  localparam logic [1:0] ERR_PUSH_FULL = 2'd2;

  // Command broadcast to every cell of the chain in the cycle of an accepted beat.
  typedef struct packed {
    logic              push;
    logic              pop;
    logic signed [7:0] value;
  } cell_cmd_t;

endpackage

/* sv/ssq_cell.sv */
// One compare-and-shift cell of the sorted chain.
module ssq_cell (
  input  logic                  clk,
  input  ssq_pkg::cell_cmd_t    cmd,
  input  logic                  occupied,
  input  logic                  upper_le,
  input  logic signed [7:0]     upper_val,
  input  logic signed [7:0]     lower_val,
  output logic signed [7:0]     val,
  output logic                  le
);

  logic signed [7:0] val_next;

  // The cell keeps its entry when it holds a value not above the new one.
  assign le = occupied && (val <= cmd.value);

  always_comb begin
    val_next = val;
    if (cmd.push) begin
      if (!le) begin
        // The first cell past the stop point takes the new value; the rest shift down.
        val_next = upper_le ? cmd.value : upper_val;
      end
    end else if (cmd.pop) begin
      val_next = lower_val;
    end
  end

  always_ff @(posedge clk) begin
    val <= val_next;
  end

endmodule

/* sv/sorted_stack_priority_queue.sv */
// Top level of the sorted-stack min priority queue built as a chain of cells.
//
//  channel   | handshake          | payload
//  ----------+--------------------+------------------------------------------------
//  command   | start / busy       | kind, value
//  result    | done (strobe)      | popped_value, popped_valid, top_value,
//            |                    | is_empty_flag, entry_count, error_code
//
// A command beat is taken at an edge with start high and busy low. Each cell
// compares its entry against the pushed value and shifts in parallel, so a whole
// insertion or removal completes at the accepting edge and one beat per cycle
// can be taken. The result appears in the next cycle and done is high for
// exactly that cycle; the receiver cannot stall it. Busy is high only during
// reset and in the cycle after it. Reset clears the entry count; entry contents
// are left as they are, since only entries below the count are ever read.
module sorted_stack_priority_queue #(
  parameter int DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic              kind,
  input  logic signed [7:0] value,
  output logic              done,
  output logic signed [7:0] popped_value,
  output logic              popped_valid,
  output logic signed [7:0] top_value,
  output logic              is_empty_flag,
  output logic [4:0]        entry_count,
  output logic [1:0]        error_code
);

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0]      count;
  logic [CW-1:0]      count_next;
  logic               accept;
  logic               full;
  logic               empty;
  logic               do_push;
  logic               do_pop;
  logic signed [7:0]  top_next;
  logic [1:0]         err_next;
  ssq_pkg::cell_cmd_t cmd;

  logic signed [7:0]  cell_val [DEPTH];
  logic               cell_le  [DEPTH];

  assign accept  = start && !busy;
  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = accept && (kind == ssq_pkg::KIND_PUSH) && !full;
  assign do_pop  = accept && (kind == ssq_pkg::KIND_POP) && !empty;

  // Every cell sees the same command; a refused beat reaches them as no operation.
  assign cmd = '{push: do_push, pop: do_pop, value: value};

  // The chain: index 0 is the top of the stack and holds the smallest entry.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic              occ;
    logic              up_le;
    logic signed [7:0] up_val;
    logic signed [7:0] low_val;

    assign occ = (count > CW'(i));

    if (i == 0) begin : g_first
      assign up_le  = 1'b1;
      assign up_val = '0;
    end else begin : g_inner
      assign up_le  = cell_le[i-1];
      assign up_val = cell_val[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign low_val = '0;
    end else begin : g_upper
      assign low_val = cell_val[i+1];
    end

    ssq_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .occupied  (occ),
      .upper_le  (up_le),
      .upper_val (up_val),
      .lower_val (low_val),
      .val       (cell_val[i]),
      .le        (cell_le[i])
    );
  end

  // Count, top value and error code as they stand after this beat.
  always_comb begin
    count_next = count;
    err_next   = ssq_pkg::ERR_OK;
    top_next   = cell_val[0];
    if (accept) begin
      if (kind == ssq_pkg::KIND_PUSH) begin
        if (full) begin
          err_next = ssq_pkg::ERR_PUSH_FULL;
        end else begin
          count_next = count + CW'(1);
          // The new value lands on top when nothing stored is at or below it.
          if (!cell_le[0]) begin
            top_next = value;
          end
        end
      end else begin
        if (empty) begin
          err_next = ssq_pkg::ERR_POP_EMPTY;
        end else begin
          count_next = count - CW'(1);
          top_next   = cell_val[1];
        end
      end
    end
    if (count_next == '0) begin
      top_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      busy  <= 1'b1;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      busy  <= 1'b0;
      done  <= accept;
    end
  end

  // Result payload; it is only looked at while done is high.
  always_ff @(posedge clk) begin
    popped_value  <= do_pop ? cell_val[0] : 8'sd0;
    popped_valid  <= do_pop;
    top_value     <= top_next;
    is_empty_flag <= (count_next == '0);
    entry_count   <= 5'(count_next);
    error_code    <= err_next;
  end

  // A result strobe always follows an accepted command beat.
  a_done_follows_accept: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy))
    else $error("result strobe without an accepted command");

  // The empty flag agrees with the stored count.
  a_empty_matches_count: assert property (@(posedge clk) disable iff (rst)
    done |-> (is_empty_flag == (count == '0)))
    else $error("empty flag disagrees with entry count");

  // The count never passes the depth of the chain.
  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count beyond depth");

  // A successful pop removes exactly one entry.
  a_pop_decrements: assert property (@(posedge clk) disable iff (rst)
    (done && popped_valid) |-> (count == $past(count) - CW'(1)))
    else $error("pop did not remove one entry");

  // A refused beat leaves the stack as it was.
  a_error_keeps_count: assert property (@(posedge clk) disable iff (rst)
    (done && (error_code != ssq_pkg::ERR_OK)) |-> (count == $past(count) && !popped_valid))
    else $error("refused beat changed the stack");

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench of the sorted-stack min priority queue.
module testbench;

  localparam int DEPTH = 16;

  // One result beat as the block reports it.
  typedef struct packed {
    logic signed [7:0] popped;
    logic              popped_ok;
    logic signed [7:0] top;
    logic              empty;
    logic [4:0]        count;
    logic [1:0]        err;
  } queue_result_t;

  // One row of the directed stimulus table. When pinned is set the expected
  // result is taken from the row instead of from the shadow queue.
  typedef struct {
    logic              kind;
    logic signed [7:0] value;
    bit                pinned;
    queue_result_t     res;
  } stim_row_t;

  logic              clk;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic              kind = ssq_pkg::KIND_PUSH;
  logic signed [7:0] value = '0;
  logic              done;
  logic signed [7:0] popped_value;
  logic              popped_valid;
  logic signed [7:0] top_value;
  logic              is_empty_flag;
  logic [4:0]        entry_count;
  logic [1:0]        error_code;

  // A pinned expectation travels with the command beat, driven on the same
  // edges as start, so the checker picks it up exactly at the accepting edge.
  bit                pin_on = 1'b0;
  queue_result_t     pin_res = '0;

  // Shadow copy of the sorted stack; index 0 is the top (smallest entry).
  logic signed [7:0] shadow_stack [DEPTH];
  int                shadow_count = 0;

  queue_result_t     expected_q [$];
  stim_row_t         directed_rows [$];
  int                fail_count = 0;

  sorted_stack_priority_queue #(
    .DEPTH(DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .kind(kind),
    .value(value),
    .done(done),
    .popped_value(popped_value),
    .popped_valid(popped_valid),
    .top_value(top_value),
    .is_empty_flag(is_empty_flag),
    .entry_count(entry_count),
    .error_code(error_code)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop in case the block hangs, with a wide margin over the slowest
  // correct run.
  initial begin
    #200000;
    $display("testbench NOT OK");
    $finish;
  end

  // Applies one command to the shadow stack and returns the result the block
  // must report for it. A push walks past every entry less than or equal to the
  // new value, so a new value lands below all equal ones already stored.
  function automatic queue_result_t shadow_apply(input logic op,
                                                 input logic signed [7:0] v);
    queue_result_t r;
    int pos;
    int i;
    r = '0;
    r.err = ssq_pkg::ERR_OK;
    if (op == ssq_pkg::KIND_PUSH) begin
      if (shadow_count >= DEPTH) begin
        // Full: the push is dropped and the stack stays as it is.
        r.err = ssq_pkg::ERR_PUSH_FULL;
      end else begin
        pos = 0;
        while (pos < shadow_count && shadow_stack[pos] <= v) pos++;
        for (i = shadow_count; i > pos; i--) shadow_stack[i] = shadow_stack[i - 1];
        shadow_stack[pos] = v;
        shadow_count++;
      end
    end else begin
      if (shadow_count == 0) begin
        // Empty: nothing to remove, the popped fields stay zero.
        r.err = ssq_pkg::ERR_POP_EMPTY;
      end else begin
        r.popped = shadow_stack[0];
        r.popped_ok = 1'b1;
        for (i = 1; i < shadow_count; i++) shadow_stack[i - 1] = shadow_stack[i];
        shadow_count--;
      end
    end
    r.top = (shadow_count != 0) ? shadow_stack[0] : 8'sd0;
    r.empty = (shadow_count == 0);
    r.count = 5'(shadow_count);
    return r;
  endfunction

  function automatic queue_result_t make_result(input logic signed [7:0] pv, input logic ok,
                                                input logic signed [7:0] tv, input logic em,
                                                input logic [4:0] cnt, input logic [1:0] e);
    make_result = '{popped: pv, popped_ok: ok, top: tv, empty: em, count: cnt, err: e};
  endfunction

  task automatic add_row(input logic op, input logic signed [7:0] v, input bit pin,
                         input queue_result_t res);
    stim_row_t row;
    row.kind = op;
    row.value = v;
    row.pinned = pin;
    row.res = res;
    directed_rows.push_back(row);
  endtask

  task automatic compare_field(input string fname, input logic signed [8:0] want,
                               input logic signed [8:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, want, got);
      fail_count++;
    end
  endtask

  // Offers one command beat and returns at the edge that accepts it. Start is
  // left high, so a following beat can go out on the very next edge.
  task automatic send_beat(input logic op, input logic signed [7:0] v, input bit pin,
                           input queue_result_t res);
    start <= 1'b1;
    kind <= op;
    value <= v;
    pin_on <= pin;
    pin_res <= res;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Before the next beat, idles each cycle with the given chance in a hundred,
  // so that share of all cycles ends up idle.
  task automatic maybe_pause(input int pct);
    if ($urandom_range(99) < pct) begin
      start <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < pct) @(posedge clk);
    end
  endtask

  // Mixes the extremes, a narrow band that makes many equal entries, and the
  // full signed range.
  function automatic logic signed [7:0] pick_value();
    int sel;
    sel = $urandom_range(99);
    if (sel < 20) begin
      case ($urandom_range(3))
        0: pick_value = -8'sd128;
        1: pick_value = 8'sd127;
        2: pick_value = 8'sd0;
        default: pick_value = -8'sd1;
      endcase
    end else if (sel < 45) begin
      pick_value = 8'($signed($urandom_range(8)) - 4);
    end else begin
      pick_value = 8'($urandom);
    end
  endfunction

  // Result checker. Results are sampled at the edge that ends their strobe
  // cycle, and a command beat counts as taken at an edge with start high and
  // busy low. Both sides are read before the edge updates anything.
  always @(posedge clk) begin : result_check
    queue_result_t got;
    queue_result_t want;
    queue_result_t modeled;
    if (!rst) begin
      if (done) begin
        got = '{popped: popped_value, popped_ok: popped_valid, top: top_value,
                empty: is_empty_flag, count: entry_count, err: error_code};
        if (expected_q.size() == 0) begin
          $display("%0t: result beat arrived with no command outstanding", $time);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          compare_field("popped_value", 9'(want.popped), 9'(got.popped));
          compare_field("popped_valid", 9'(want.popped_ok), 9'(got.popped_ok));
          compare_field("top_value", 9'(want.top), 9'(got.top));
          compare_field("is_empty_flag", 9'(want.empty), 9'(got.empty));
          compare_field("entry_count", 9'(want.count), 9'(got.count));
          compare_field("error_code", 9'(want.err), 9'(got.err));
        end
      end
      if (start && !busy) begin
        // The shadow stack always advances, even when the row pins the answer.
        modeled = shadow_apply(kind, value);
        expected_q.push_back(pin_on ? pin_res : modeled);
      end
    end
  end

  initial begin : stimulus
    queue_result_t none;
    stim_row_t     row;
    int            phase;
    int            n;
    int            idle_pct;
    int            push_pct;
    logic          op;
    none = '0;

    // Directed table. First a pop on the empty stack, then sixteen pushes that
    // cover both extremes, repeated values and alternating bit patterns until
    // the stack is full, a push that must bounce off the full stack, and pops
    // that drain the smallest entries in order.
    add_row(ssq_pkg::KIND_POP, 8'sd77, 1'b1,
            make_result(8'sd0, 1'b0, 8'sd0, 1'b1, 5'd0, ssq_pkg::ERR_POP_EMPTY));
    add_row(ssq_pkg::KIND_PUSH, 8'sd127, 1'b1,
            make_result(8'sd0, 1'b0, 8'sd127, 1'b0, 5'd1, ssq_pkg::ERR_OK));
    add_row(ssq_pkg::KIND_PUSH, -8'sd128, 1'b1,
            make_result(8'sd0, 1'b0, -8'sd128, 1'b0, 5'd2, ssq_pkg::ERR_OK));
    add_row(ssq_pkg::KIND_PUSH, 8'sd0, 1'b0, none);
    add_row(ssq_pkg::KIND_PUSH, 8'sd0, 1'b0, none);
    add_row(ssq_pkg::KIND_PUSH, -8'sd1, 1'b0, none);
    add_row(ssq_pkg::KIND_PUSH, 8'sd1, 1'b0, none);
    add_row(ssq_pkg::KIND_PUSH, 8'sd127, 1'b0, none);
    add_row(ssq_pkg::KIND_PUSH, -8'sd128, 1'b0, none);
    add_row(ssq_pkg::KIND_PUSH, 8'sd85, 1'b0, none);
    add_row(ssq_pkg::KIND_PUSH, -8'sd86, 1'b0, none);
    add_row(ssq_pkg::KIND_PUSH, 8'sd42, 1'b0, none);
    add_row(ssq_pkg::KIND_PUSH, 8'sd42, 1'b0, none);
    add_row(ssq_pkg::KIND_PUSH, -8'sd42, 1'b0, none);
    add_row(ssq_pkg::KIND_PUSH, 8'sd100, 1'b0, none);
    add_row(ssq_pkg::KIND_PUSH, -8'sd100, 1'b0, none);
    add_row(ssq_pkg::KIND_PUSH, 8'sd3, 1'b0, none);
    add_row(ssq_pkg::KIND_PUSH, 8'sd5, 1'b1,
            make_result(8'sd0, 1'b0, -8'sd128, 1'b0, 5'd16, ssq_pkg::ERR_PUSH_FULL));
    add_row(ssq_pkg::KIND_POP, -8'sd1, 1'b1,
            make_result(-8'sd128, 1'b1, -8'sd128, 1'b0, 5'd15, ssq_pkg::ERR_OK));
    repeat (6) add_row(ssq_pkg::KIND_POP, 8'sd0, 1'b0, none);

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      send_beat(row.kind, row.value, row.pinned, row.res);
      maybe_pause(28);
    end

    // Random part in three stretches: the sender pauses often, then very often,
    // then never. The push share is drawn anew every forty beats so that the stack
    // keeps running into both the empty and the full end.
    push_pct = 50;
    for (phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 28 : (phase == 1) ? 69 : 0;
      for (n = 0; n < 375; n++) begin
        if (n % 40 == 0) begin
          case ($urandom_range(3))
            0: push_pct = 15;
            1: push_pct = 50;
            2: push_pct = 85;
            default: push_pct = 97;
          endcase
        end
        op = ($urandom_range(99) < push_pct) ? ssq_pkg::KIND_PUSH : ssq_pkg::KIND_POP;
        send_beat(op, pick_value(), 1'b0, none);
        maybe_pause(idle_pct);
      end
    end

    start <= 1'b0;
    pin_on <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (expected_q.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, expected_q.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/ssq_pkg.sv
sv/ssq_cell.sv
sv/sorted_stack_priority_queue.sv
dv/testbench.sv
